@@ hdl/linear_probe_hash_table_macros.svh @@
// Assertion macros shared by the hash table RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define LPHT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define LPHT_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define LPHT_ASSERT(lbl, clk, rst, prop, msg)
`define LPHT_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`endif
`endif

@@ hdl/lpht_pkg.sv @@
// Types, constants and helper functions for the linear probing hash table.
// Has no dependencies; imported by every module of the block but lpht_ram.
`default_nettype none
package lpht_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CAP_W = 11;
  localparam int CAPE_W = (IDX_W + 1 < CAP_W) ? IDX_W + 1 : CAP_W;
  localparam int REM_W = CAPE_W + 1;

  localparam int FUNC_W = 2;
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int STATUS_W = 3;
  localparam int HASH_W = 64;
  localparam int HALF_W = HASH_W / 2;

  localparam logic [HASH_W-1:0] GOLDEN_MUL = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [KEY_W-1:0] SENTINEL = 32'hFFFF_FFFF;

  localparam int MOD_RADIX = 4;
  localparam int MOD_STEPS = HASH_W / MOD_RADIX;
  localparam int MODCNT_W = $clog2(MOD_STEPS);

  localparam int Q_DEPTH = 2;
  localparam int QPTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNINIT = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SENTKEY = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL = 3'd4;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } lpht_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0] found_value;
  } lpht_out_t;

  typedef enum logic [1:0] {
    OP_LOOKUP,
    OP_INSERT,
    OP_CLEAR,
    OP_REPORT
  } op_t;

  typedef struct packed {
    op_t op;
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] home;
    logic [CAPE_W-1:0] cap;
  } job_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL_LO,
    F_MUL_HI,
    F_FOLD,
    F_MOD,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_INIT,
    B_IDLE,
    B_PROBE,
    B_CLEAR,
    B_EMIT
  } back_state_t;

  function automatic logic [CAPE_W-1:0] eff_cap(input logic [CAP_W-1:0] c);
    logic [31:0] wide;
    wide = {{(32 - CAP_W){1'b0}}, c};
    if (wide > 32'(TABLE_DEPTH)) begin
      return CAPE_W'(TABLE_DEPTH);
    end
    return CAPE_W'(c);
  endfunction

endpackage
`default_nettype wire

@@ hdl/linear_probe_hash_table.sv @@
// Hash map top level: a lookup or insert passes through the hash, the modulo and P probes;
// an item that needs no probe skips all of them, and a clear sweeps every slot of both stores.
// The hash and 4-bit-per-cycle modulo unit takes no new item until the last one is in the
// queue; the probe engine reads one slot per cycle while it probes for an item.
// Synchronous reset sets capacity to zero and runs a clearing pass over all 1024 slots
// of both stores, during which full stays high.
`default_nettype none
module linear_probe_hash_table
  import lpht_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  lpht_in_t         item,
  output logic             empty,
  input  logic             pop,
  output lpht_out_t        result,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata
);

  logic [CAP_W-1:0] capacity;
  logic [CAPE_W-1:0] cap_eff;
  logic init_busy;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  job_t q_wjob;
  job_t q_rjob;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= '0;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  assign cap_eff = eff_cap(capacity);

  lpht_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item     (item),
    .full     (full),
    .cap_eff  (cap_eff),
    .init_busy(init_busy),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (q_wjob)
  );

  lpht_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .wjob (q_wjob),
    .full (q_full),
    .pop  (q_pop),
    .empty(q_empty),
    .rjob (q_rjob)
  );

  lpht_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_job    (q_rjob),
    .q_pop    (q_pop),
    .init_busy(init_busy),
    .pop      (pop),
    .empty    (empty),
    .result   (result)
  );

endmodule
`default_nettype wire

@@ hdl/lpht_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Has no dependencies.
`default_nettype none
module lpht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ hdl/lpht_front.sv @@
// Front end: accepts items, classifies them and computes the home slot.
// Depends on lpht_pkg and the assertion macros.
`default_nettype none
`include "linear_probe_hash_table_macros.svh"
module lpht_front
  import lpht_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lpht_in_t          item,
  output logic              full,
  input  logic [CAPE_W-1:0] cap_eff,
  input  logic              init_busy,
  input  logic              q_full,
  output logic              q_push,
  output job_t              q_job
);

  front_state_t state, state_next;
  job_t job, job_in;
  logic accept;
  logic [KEY_W-1:0] mix;
  logic [HALF_W-1:0] mul_b;
  logic [HASH_W-1:0] prod;
  logic [HASH_W-1:0] prod_lo;
  logic [HALF_W-1:0] prod_hi;
  logic [HALF_W-1:0] hi_sum;
  logic [HASH_W-1:0] dividend;
  logic [CAPE_W-1:0] rem;
  logic [CAPE_W-1:0] rem_step;
  logic [MODCNT_W-1:0] mod_cnt;
  logic mod_last;

  assign accept = push && !full;
  assign mod_last = (mod_cnt == MODCNT_W'(MOD_STEPS - 1));

  always_comb begin
    job_in = '0;
    job_in.key = item.key;
    job_in.value = item.value;
    job_in.cap = cap_eff;
    job_in.status = ST_OK;
    job_in.op = OP_REPORT;
    unique case (item.func)
      FUNC_LOOKUP: begin
        if (cap_eff == '0 || item.key == SENTINEL) begin
          job_in.status = ST_MISS;
        end else begin
          job_in.op = OP_LOOKUP;
        end
      end
      FUNC_INSERT: begin
        if (cap_eff == '0) begin
          job_in.status = ST_UNINIT;
        end else if (item.key == SENTINEL) begin
          job_in.status = ST_SENTKEY;
        end else begin
          job_in.op = OP_INSERT;
        end
      end
      FUNC_CLEAR: begin
        job_in.op = OP_CLEAR;
      end
      FUNC_NOP: begin
        job_in.op = OP_REPORT;
      end
    endcase
  end

  assign mul_b = (state == F_MUL_LO) ? GOLDEN_MUL[HALF_W-1:0] : GOLDEN_MUL[HASH_W-1:HALF_W];
  assign prod = {{HALF_W{1'b0}}, mix} * {{HALF_W{1'b0}}, mul_b};
  assign hi_sum = prod_lo[HASH_W-1:HALF_W] + prod_hi;

  always_comb begin
    logic [REM_W-1:0] r;
    r = {1'b0, rem};
    for (int i = 0; i < MOD_RADIX; i++) begin
      r = {r[CAPE_W-1:0], dividend[HASH_W-1-i]};
      if (r >= {1'b0, job.cap}) begin
        r = r - {1'b0, job.cap};
      end
    end
    rem_step = r[CAPE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    full = (state != F_IDLE) || init_busy;
    q_push = (state == F_PUSH) && !q_full;
    q_job = job;
    unique case (state)
      F_IDLE: begin
        if (accept) begin
          if (job_in.op == OP_LOOKUP || job_in.op == OP_INSERT) begin
            state_next = F_MUL_LO;
          end else begin
            state_next = F_PUSH;
          end
        end
      end
      F_MUL_LO: state_next = F_MUL_HI;
      F_MUL_HI: state_next = F_FOLD;
      F_FOLD: state_next = F_MOD;
      F_MOD: begin
        if (mod_last) begin
          state_next = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job <= job_in;
      mix <= item.key ^ (item.key >> 16);
    end else if (state == F_MOD && mod_last) begin
      job.home <= IDX_W'(rem_step);
    end
    if (state == F_MUL_LO) begin
      prod_lo <= prod;
    end
    if (state == F_MUL_HI) begin
      prod_hi <= prod[HALF_W-1:0];
    end
    if (state == F_FOLD) begin
      dividend <= {hi_sum, prod_lo[HALF_W-1:0] ^ hi_sum};
      rem <= '0;
      mod_cnt <= '0;
    end else if (state == F_MOD) begin
      dividend <= dividend << MOD_RADIX;
      rem <= rem_step;
      mod_cnt <= mod_cnt + MODCNT_W'(1);
    end
  end

  `LPHT_ASSERT_IMPL(a_mod_cap_nonzero, clk, rst, state == F_MOD, job.cap != '0,
    "Modulo started with a zero capacity.")
  `LPHT_ASSERT_IMPL(a_rem_below_cap, clk, rst, state == F_MOD, rem < job.cap,
    "Partial remainder reached the capacity.")

endmodule
`default_nettype wire

@@ hdl/lpht_queue.sv @@
// Short job queue between the front end and the probe engine.
// Depends on lpht_pkg and the assertion macros.
`default_nettype none
`include "linear_probe_hash_table_macros.svh"
module lpht_queue
  import lpht_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t wjob,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t rjob
);

  job_t entries [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic do_push;
  logic do_pop;

  assign full = (count == QCNT_W'(Q_DEPTH));
  assign empty = (count == '0);
  assign rjob = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = pop && !empty;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(Q_DEPTH - 1)) begin
      return '0;
    end
    return p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wjob;
    end
  end

  `LPHT_ASSERT(a_count_bound, clk, rst, count <= QCNT_W'(Q_DEPTH),
    "Queue count exceeds its depth.")
  `LPHT_ASSERT_IMPL(a_no_push_full, clk, rst, push, !full,
    "Job pushed into a full queue.")

endmodule
`default_nettype wire

@@ hdl/lpht_back.sv @@
// Probe engine: owns the key and value stores, runs probes, clears and results.
// Depends on lpht_pkg, lpht_ram and the assertion macros.
`default_nettype none
`include "linear_probe_hash_table_macros.svh"
module lpht_back
  import lpht_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      q_empty,
  input  job_t      q_job,
  output logic      q_pop,
  output logic      init_busy,
  input  logic      pop,
  output logic      empty,
  output lpht_out_t result
);

  back_state_t state, state_next;
  job_t cur;
  logic [IDX_W-1:0] pos;
  logic [IDX_W-1:0] pos_nx;
  logic [CAPE_W-1:0] pos_inc;
  logic [CAPE_W-1:0] cnt;
  logic [CAPE_W-1:0] cnt_inc;
  logic [IDX_W-1:0] sweep;
  logic sweep_last;
  lpht_out_t res;
  lpht_out_t probe_res;
  logic out_valid;
  lpht_out_t out_res;
  logic out_free;

  logic ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [KEY_W-1:0] key_wdata;
  logic [VAL_W-1:0] val_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [KEY_W-1:0] rd_key;
  logic [VAL_W-1:0] rd_val;

  logic slot_empty;
  logic slot_match;
  logic stop;
  logic last_probe;

  lpht_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) key_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(key_wdata),
    .raddr(ram_raddr),
    .rdata(rd_key)
  );

  lpht_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_DEPTH)) value_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(val_wdata),
    .raddr(ram_raddr),
    .rdata(rd_val)
  );

  assign pos_inc = CAPE_W'(pos) + CAPE_W'(1);
  assign pos_nx = (pos_inc == cur.cap) ? '0 : IDX_W'(pos_inc);
  assign cnt_inc = cnt + CAPE_W'(1);
  assign last_probe = (cnt_inc == cur.cap);
  assign sweep_last = (sweep == IDX_W'(TABLE_DEPTH - 1));
  assign slot_empty = (rd_key == SENTINEL);
  assign slot_match = (rd_key == cur.key);
  assign stop = slot_empty || slot_match;
  assign out_free = !out_valid || pop;
  assign empty = !out_valid;
  assign result = out_res;

  always_comb begin
    probe_res = '0;
    if (cur.op == OP_LOOKUP) begin
      probe_res.status = ST_MISS;
      if (slot_match && !slot_empty && rd_val != SENTINEL) begin
        probe_res.status = ST_OK;
        probe_res.found_value = rd_val;
      end
    end else begin
      probe_res.status = stop ? ST_OK : ST_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    init_busy = (state == B_INIT);
    ram_we = 1'b0;
    ram_waddr = sweep;
    key_wdata = SENTINEL;
    val_wdata = SENTINEL;
    ram_raddr = pos_nx;
    unique case (state)
      B_INIT: begin
        ram_we = 1'b1;
        if (sweep_last) begin
          state_next = B_IDLE;
        end
      end
      B_IDLE: begin
        ram_raddr = q_job.home;
        if (!q_empty) begin
          q_pop = 1'b1;
          unique case (q_job.op)
            OP_LOOKUP, OP_INSERT: state_next = B_PROBE;
            OP_CLEAR: state_next = B_CLEAR;
            OP_REPORT: state_next = B_EMIT;
          endcase
        end
      end
      B_PROBE: begin
        if (cur.op == OP_INSERT && stop) begin
          ram_we = 1'b1;
          ram_waddr = pos;
          key_wdata = cur.key;
          val_wdata = cur.value;
        end
        if (stop || last_probe) begin
          state_next = B_EMIT;
        end
      end
      B_CLEAR: begin
        ram_we = 1'b1;
        if (sweep_last) begin
          state_next = B_EMIT;
        end
      end
      B_EMIT: begin
        if (out_free) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == B_INIT || state == B_CLEAR) begin
        sweep <= sweep + IDX_W'(1);
      end else if (state == B_IDLE) begin
        sweep <= '0;
      end
      if (state == B_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_IDLE && !q_empty) begin
      cur <= q_job;
      pos <= q_job.home;
      cnt <= '0;
      res.status <= q_job.status;
      res.found_value <= '0;
    end else if (state == B_PROBE) begin
      if (stop || last_probe) begin
        res <= probe_res;
      end else begin
        pos <= pos_nx;
        cnt <= cnt_inc;
      end
    end
    if (state == B_EMIT && out_free) begin
      out_res <= res;
    end
  end

  `LPHT_ASSERT_IMPL(a_pos_in_range, clk, rst, state == B_PROBE, CAPE_W'(pos) < cur.cap,
    "Probe slot lies outside the capacity.")
  `LPHT_ASSERT_IMPL(a_cnt_in_range, clk, rst, state == B_PROBE, cnt < cur.cap,
    "Probe count ran past the capacity.")

endmodule
`default_nettype wire

@@ bench/tb_linear_probe_hash_table.sv @@
// Testbench for linear_probe_hash_table: drives lookups, inserts, clears and the unused code
// through the queue-style ports, predicts every reply and compares it field by field.
// Depends on lpht_pkg and the hash table RTL; needs nothing else.
`timescale 1ns / 1ps

module tb_linear_probe_hash_table;
  import lpht_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int SETTLE_CYCLES = 40;
  localparam int POOL_SIZE = 48;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  lpht_in_t item = '0;
  logic empty;
  logic pop = 1'b0;
  lpht_out_t result;
  logic cfg_we = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = '0;

  logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
  logic [VAL_W-1:0] val_mem [TABLE_DEPTH];
  logic [CAP_W-1:0] model_cap = '0;
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  lpht_out_t reply_q[$];
  lpht_out_t want;
  int mismatch_count = 0;
  int stall_pct = 0;
  int gap_max = 0;
  int burst_left = 0;

  linear_probe_hash_table dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void clear_model_stores();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      key_mem[i] = SENTINEL;
      val_mem[i] = SENTINEL;
    end
  endfunction

  function automatic logic [HASH_W-1:0] mix_node_id(input logic [KEY_W-1:0] k);
    logic [HASH_W-1:0] x;
    x = {{(HASH_W - KEY_W){1'b0}}, k};
    x = x ^ (x >> 16);
    x = x * GOLDEN_MUL;
    x = x ^ (x >> HALF_W);
    return x;
  endfunction

  function automatic lpht_out_t model_table_op(input lpht_in_t it);
    lpht_out_t r;
    int unsigned slots;
    int unsigned pos;
    r.status = ST_OK;
    r.found_value = '0;
    slots = (model_cap > TABLE_DEPTH) ? TABLE_DEPTH : model_cap;
    case (it.func)
      FUNC_LOOKUP: begin
        r.status = ST_MISS;
        if (slots != 0) begin
          pos = 32'(mix_node_id(it.key) % 64'(slots));
          for (int n = 0; n < slots; n++) begin
            if (key_mem[pos] == SENTINEL) break;
            if (key_mem[pos] == it.key) begin
              if (val_mem[pos] != SENTINEL) begin
                r.status = ST_OK;
                r.found_value = val_mem[pos];
              end
              break;
            end
            pos = (pos + 1 == slots) ? 0 : pos + 1;
          end
        end
      end
      FUNC_INSERT: begin
        if (slots == 0) begin
          r.status = ST_UNINIT;
        end else if (it.key == SENTINEL) begin
          r.status = ST_SENTKEY;
        end else begin
          r.status = ST_FULL;
          pos = 32'(mix_node_id(it.key) % 64'(slots));
          for (int n = 0; n < slots; n++) begin
            if (key_mem[pos] == SENTINEL || key_mem[pos] == it.key) begin
              key_mem[pos] = it.key;
              val_mem[pos] = it.value;
              r.status = ST_OK;
              break;
            end
            pos = (pos + 1 == slots) ? 0 : pos + 1;
          end
        end
      end
      FUNC_CLEAR: begin
        clear_model_stores();
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // The reply is predicted in the step of the transfer, so the model sees items in order.
  task automatic send_item(input lpht_in_t it);
    push <= 1'b1;
    item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    reply_q.insert(reply_q.size(), model_table_op(it));
    if (gap_max != 0) begin
      if (burst_left == 0) begin
        push <= 1'b0;
        repeat ($urandom_range(gap_max, 1)) @(posedge clk);
        burst_left = $urandom_range(8, 0);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_op(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k,
                         input logic [VAL_W-1:0] v);
    lpht_in_t it;
    it.func = f;
    it.key = k;
    it.value = v;
    send_item(it);
  endtask

  task automatic stop_push();
    push <= 1'b0;
  endtask

  task automatic wait_idle();
    while (reply_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] c);
    cfg_we <= 1'b1;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_cap = c;
  endtask

  task automatic run_mixed_phase(input logic [CAP_W-1:0] cap, input int n_items,
                                 input int pool_n, input bit clear_first,
                                 input int stall, input int gaps);
    lpht_in_t it;
    int pick;
    wait_idle();
    set_capacity(cap);
    stall_pct <= stall;
    gap_max = gaps;
    burst_left = $urandom_range(8, 0);
    if (clear_first) begin
      send_op(FUNC_CLEAR, $urandom(), $urandom());
    end
    repeat (n_items) begin
      pick = $urandom_range(99, 0);
      it.key = key_pool[$urandom_range(pool_n - 1, 0)];
      it.value = ($urandom_range(19, 0) == 0) ? SENTINEL : $urandom();
      if (pick < 45) begin
        it.func = FUNC_INSERT;
      end else if (pick < 85) begin
        it.func = FUNC_LOOKUP;
      end else if (pick < 91) begin
        it.func = pick[0] ? FUNC_INSERT : FUNC_LOOKUP;
        it.key = $urandom();
      end else if (pick < 94) begin
        it.func = pick[0] ? FUNC_INSERT : FUNC_LOOKUP;
        it.key = SENTINEL;
      end else if (pick < 96) begin
        it.func = FUNC_CLEAR;
      end else begin
        it.func = FUNC_NOP;
        it.key = $urandom();
      end
      send_item(it);
    end
    stop_push();
  endtask

  task automatic test_uninitialized();
    gap_max = 0;
    stall_pct <= 30;
    send_op(FUNC_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_op(FUNC_INSERT, 32'h0000_0001, 32'h1234_5678);
    send_op(FUNC_INSERT, SENTINEL, 32'h0000_0001);
    send_op(FUNC_LOOKUP, SENTINEL, SENTINEL);
    send_op(FUNC_NOP, SENTINEL, SENTINEL);
    send_op(FUNC_CLEAR, 32'h0000_0000, 32'h0000_0000);
    stop_push();
  endtask

  task automatic test_single_slot();
    wait_idle();
    set_capacity(11'd1);
    send_op(FUNC_INSERT, 32'h0000_0000, 32'h0000_0000);
    send_op(FUNC_LOOKUP, 32'h0000_0000, SENTINEL);
    send_op(FUNC_INSERT, 32'h0000_0000, SENTINEL);
    send_op(FUNC_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_op(FUNC_INSERT, 32'hFFFF_FFFE, 32'h0000_0005);
    send_op(FUNC_LOOKUP, 32'hFFFF_FFFE, 32'h0000_0000);
    send_op(FUNC_INSERT, SENTINEL, 32'h0000_0007);
    send_op(FUNC_LOOKUP, SENTINEL, 32'h0000_0000);
    send_op(FUNC_INSERT, 32'h0000_0000, 32'hA5A5_5A5A);
    send_op(FUNC_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    stop_push();
  endtask

  task automatic test_saturated_capacity();
    wait_idle();
    set_capacity(11'd2047);
    send_op(FUNC_INSERT, 32'hFFFF_FFFE, 32'hFFFF_FFFE);
    send_op(FUNC_LOOKUP, 32'hFFFF_FFFE, 32'h0000_0000);
    send_op(FUNC_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_op(FUNC_CLEAR, 32'h5555_5555, 32'hAAAA_AAAA);
    send_op(FUNC_LOOKUP, 32'hFFFF_FFFE, 32'h0000_0000);
    stop_push();
    wait_idle();
    set_capacity(11'd1024);
    send_op(FUNC_INSERT, 32'h1234_5678, 32'h8765_4321);
    send_op(FUNC_LOOKUP, 32'h1234_5678, 32'h0000_0000);
    stop_push();
  endtask

  task automatic test_small_tables();
    run_mixed_phase(11'd5, 60, 8, 1'b1, 20, 4);
    run_mixed_phase(11'd1, 30, 3, 1'b0, 0, 0);
  endtask

  // Entries are kept across the capacity writes, so later probes see stale placements.
  task automatic test_capacity_change();
    run_mixed_phase(11'd2047, 100, POOL_SIZE, 1'b0, 50, 6);
    run_mixed_phase(11'd13, 60, 20, 1'b0, 10, 2);
    run_mixed_phase(11'd0, 30, POOL_SIZE, 1'b0, 30, 3);
  endtask

  task automatic test_large_tables();
    run_mixed_phase(11'd1024, 80, POOL_SIZE, 1'b1, 0, 0);
    run_mixed_phase(11'd300, 50, POOL_SIZE, 1'b0, 70, 8);
    run_mixed_phase(11'd1500, 40, POOL_SIZE, 1'b0, 25, 5);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99, 0) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (reply_q.size() == 0) begin
        $error("unexpected result transfer: status %0d, found_value %h",
               result.status, result.found_value);
        mismatch_count++;
      end else begin
        want = reply_q.pop_front();
        if (result.status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, result.status);
          mismatch_count++;
        end
        if (result.found_value !== want.found_value) begin
          $error("found_value mismatch: expected %h, actual %h",
                 want.found_value, result.found_value);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    clear_model_stores();
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFE;
    key_pool[2] = 32'h7FFF_FFFF;
    key_pool[3] = 32'h8000_0000;
    for (int i = 4; i < POOL_SIZE; i++) begin
      key_pool[i] = $urandom();
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_uninitialized();
    test_single_slot();
    test_saturated_capacity();
    test_small_tables();
    test_capacity_change();
    test_large_tables();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
